// File: rtl/core/hkrb_pkg.sv
// Shared types and constants for the HID key report builder.
`timescale 1ns / 1ps

package hkrb_pkg;

    localparam logic [2:0] CLS_KEY       = 3'd0;
    localparam logic [2:0] CLS_MOD       = 3'd1;
    localparam logic [2:0] CLS_MEDIA     = 3'd2;
    localparam logic [2:0] CLS_MOUSE     = 3'd3;
    localparam logic [2:0] CLS_MOMENTARY = 3'd4;
    localparam logic [2:0] CLS_TOGGLE    = 3'd5;
    localparam logic [2:0] CLS_MISC      = 3'd6;
    localparam logic [2:0] CLS_UNKNOWN   = 3'd7;

    localparam logic [7:0] MISC_BOOT     = 8'd0;
    localparam logic [7:0] MISC_BRIGHTER = 8'd1;
    localparam logic [7:0] MISC_DIMMER   = 8'd2;

    localparam logic [7:0] BR_STEP  = 8'h20;
    localparam logic [7:0] BR_UPPER = 8'hF0;
    localparam logic [7:0] BR_LOWER = 8'h10;

    localparam logic [7:0] KEY_EMPTY = 8'h00;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] key_code;
        logic       is_down;
    } request_t;

    typedef struct packed {
        logic       report_sent;
        logic [7:0] modifier_bits;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
        logic [7:0] active_layer;
        logic [7:0] led_level;
        logic       boot_request;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_first;
        logic scan_next;
        logic take;
    } dp_cmd_t;

    typedef struct packed {
        logic is_key;
        logic hit;
        logic last;
    } dp_stat_t;

endpackage

// File: rtl/core/hkrb_ctrl.sv
// Sequencer for the key report builder: decode, slot scan and result strobe.
`timescale 1ns / 1ps

module hkrb_ctrl
    import hkrb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = stat.is_key ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DECODE:
            begin
                cmd.scan_first = stat.is_key;
                cmd.exec       = !stat.is_key;
            end
            ST_SCAN:
            begin
                cmd.take      = stat.hit;
                cmd.scan_next = !stat.hit && !stat.last;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/core/hkrb_dp.sv
// Report state, slot scan pointer and per-class update logic.
`timescale 1ns / 1ps

module hkrb_dp
    import hkrb_pkg::*;
#(
    parameter int SLOT_COUNT = 6
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  request_t request,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output result_t  result
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    request_t         req_reg;
    logic [7:0]       slot_reg [SLOT_COUNT];
    logic [7:0]       slot_next [SLOT_COUNT];
    logic [7:0]       mod_reg;
    logic [7:0]       mod_next;
    logic [7:0]       layer_reg;
    logic [7:0]       layer_next;
    logic [7:0]       led_reg;
    logic [7:0]       led_next;
    logic             sent_reg;
    logic             sent_next;
    logic             boot_reg;
    logic             boot_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [7:0]       scan_value;
    logic [7:0]       shown [6];

    // press looks for an empty slot, release for the matching code
    assign scan_value  = req_reg.is_down ? KEY_EMPTY : req_reg.key_code;
    assign stat.is_key = (req_reg.req_type == CLS_KEY);
    assign stat.hit    = (slot_reg[idx_reg] == scan_value);
    assign stat.last   = (idx_reg == IDX_LAST);

    always_comb
    begin
        slot_next  = slot_reg;
        mod_next   = mod_reg;
        layer_next = layer_reg;
        led_next   = led_reg;
        sent_next  = sent_reg;
        boot_next  = boot_reg;
        idx_next   = idx_reg;

        if (cmd.load)
        begin
            sent_next = 1'b0;
            boot_next = 1'b0;
        end

        if (cmd.scan_first)
        begin
            idx_next = '0;
        end

        if (cmd.scan_next)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.take)
        begin
            slot_next[idx_reg] = req_reg.is_down ? req_reg.key_code : KEY_EMPTY;
            sent_next          = 1'b1;
        end

        if (cmd.exec)
        begin
            case (req_reg.req_type)
                CLS_MOD:
                begin
                    mod_next  = req_reg.is_down ? (mod_reg | req_reg.key_code)
                                                : (mod_reg & ~req_reg.key_code);
                    sent_next = 1'b1;
                end
                CLS_MOMENTARY:
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        slot_next[i] = KEY_EMPTY;
                    end
                    mod_next   = '0;
                    sent_next  = 1'b1;
                    layer_next = req_reg.is_down ? req_reg.key_code : 8'h00;
                end
                CLS_TOGGLE:
                begin
                    if (req_reg.is_down && (req_reg.key_code != layer_reg))
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            slot_next[i] = KEY_EMPTY;
                        end
                        mod_next   = '0;
                        sent_next  = 1'b1;
                        layer_next = req_reg.key_code;
                    end
                end
                CLS_MISC:
                begin
                    if (req_reg.is_down)
                    begin
                        case (req_reg.key_code)
                            MISC_BOOT:
                            begin
                                boot_next = 1'b1;
                            end
                            MISC_BRIGHTER:
                            begin
                                if (led_reg < BR_UPPER)
                                begin
                                    led_next = led_reg + BR_STEP;
                                end
                            end
                            MISC_DIMMER:
                            begin
                                if (led_reg > BR_LOWER)
                                begin
                                    led_next = led_reg - BR_STEP;
                                end
                            end
                            default:
                            begin
                                boot_next = boot_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    sent_next = sent_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_reg[i] <= KEY_EMPTY;
            end
            mod_reg   <= '0;
            layer_reg <= '0;
            led_reg   <= '0;
            sent_reg  <= 1'b0;
            boot_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            slot_reg  <= slot_next;
            mod_reg   <= mod_next;
            layer_reg <= layer_next;
            led_reg   <= led_next;
            sent_reg  <= sent_next;
            boot_reg  <= boot_next;
            idx_reg   <= idx_next;
        end
    end

    // slots past SLOT_COUNT show as empty
    for (genvar j = 0; j < 6; j++)
    begin : g_shown
        if (j < SLOT_COUNT)
        begin : g_live
            assign shown[j] = slot_reg[j];
        end
        else
        begin : g_pad
            assign shown[j] = KEY_EMPTY;
        end
    end

    assign result.report_sent   = sent_reg;
    assign result.modifier_bits = mod_reg;
    assign result.slot_zero     = shown[0];
    assign result.slot_one      = shown[1];
    assign result.slot_two      = shown[2];
    assign result.slot_three    = shown[3];
    assign result.slot_four     = shown[4];
    assign result.slot_five     = shown[5];
    assign result.active_layer  = layer_reg;
    assign result.led_level     = led_reg;
    assign result.boot_request  = boot_reg;

endmodule

// File: rtl/core/hid_key_report_builder.sv
// Top level of the HID boot keyboard report builder.
`timescale 1ns / 1ps

// One key event is taken when start is high and busy is low. The result is
// shown for exactly one cycle with done high; the receiver cannot stall it,
// so it must capture the result in that cycle. Modifier, layer, misc and
// ignored events go from decode straight to done. Key events scan the report
// slots one per cycle and go to done on a match or at the last slot. Busy
// drops in the cycle after done.

module hid_key_report_builder
    import hkrb_pkg::*;
#(
    parameter int SLOT_COUNT = 6
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hkrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    hkrb_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after its result");

    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

endmodule

// File: tb/tb.sv
// Self-checking testbench for hid_key_report_builder: key events in, predicted reports checked.
`timescale 1ns / 1ps

module tb;
    import hkrb_pkg::*;

    localparam int SLOT_COUNT = 6;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    hid_key_report_builder #(.SLOT_COUNT(SLOT_COUNT)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    request_t   key_events[$];
    result_t    expected_reports[$];
    result_t    next_report;
    result_t    want_report;
    int         error_count = 0;
    int         burst_left = 0;
    int         gap_left = 0;

    logic [7:0] held_slots[SLOT_COUNT];
    logic [7:0] held_mods;
    logic [7:0] cur_layer;
    logic [7:0] led_value;

    task automatic flag_error(input string msg);
        if (error_count < 40)
            $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    task automatic clear_report_state();
        held_mods = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
            held_slots[i] = KEY_EMPTY;
    endtask

    task automatic apply_key_event(input request_t rq, output result_t r);
        logic sent;
        logic boot;
        sent = 1'b0;
        boot = 1'b0;
        case (rq.req_type)
            CLS_KEY:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!sent && rq.is_down && held_slots[i] == KEY_EMPTY)
                    begin
                        held_slots[i] = rq.key_code;
                        sent = 1'b1;
                    end
                    else if (!sent && !rq.is_down && held_slots[i] == rq.key_code)
                    begin
                        held_slots[i] = KEY_EMPTY;
                        sent = 1'b1;
                    end
                end
            end
            CLS_MOD:
            begin
                if (rq.is_down)
                    held_mods = held_mods | rq.key_code;
                else
                    held_mods = held_mods & ~rq.key_code;
                sent = 1'b1;
            end
            CLS_MOMENTARY:
            begin
                clear_report_state();
                sent = 1'b1;
                cur_layer = rq.is_down ? rq.key_code : 8'h00;
            end
            CLS_TOGGLE:
            begin
                if (rq.is_down && rq.key_code != cur_layer)
                begin
                    clear_report_state();
                    sent = 1'b1;
                    cur_layer = rq.key_code;
                end
            end
            CLS_MISC:
            begin
                if (rq.is_down)
                begin
                    if (rq.key_code == MISC_BOOT)
                        boot = 1'b1;
                    else if (rq.key_code == MISC_BRIGHTER && led_value < BR_UPPER)
                        led_value = led_value + BR_STEP;
                    else if (rq.key_code == MISC_DIMMER && led_value > BR_LOWER)
                        led_value = led_value - BR_STEP;
                end
            end
            default:
            begin
            end
        endcase
        r.report_sent   = sent;
        r.modifier_bits = held_mods;
        r.slot_zero     = held_slots[0];
        r.slot_one      = held_slots[1];
        r.slot_two      = held_slots[2];
        r.slot_three    = held_slots[3];
        r.slot_four     = held_slots[4];
        r.slot_five     = held_slots[5];
        r.active_layer  = cur_layer;
        r.led_level     = led_value;
        r.boot_request  = boot;
    endtask

    function automatic void queue_event(input logic [2:0] cls, input logic [7:0] code,
                                        input logic down);
        request_t rq;
        rq.req_type = cls;
        rq.key_code = code;
        rq.is_down  = down;
        key_events.push_back(rq);
    endfunction

    // driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            request    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_key_event(request, next_report);
                expected_reports.push_back(next_report);
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (key_events.size() != 0)
                begin
                    request <= key_events.pop_front();
                    start   <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_reports.size() == 0)
                flag_error("result with no request outstanding");
            else
            begin
                want_report = expected_reports.pop_front();
                check_field("report_sent", 8'(result.report_sent),
                            8'(want_report.report_sent));
                check_field("modifier_bits", result.modifier_bits, want_report.modifier_bits);
                check_field("slot_zero", result.slot_zero, want_report.slot_zero);
                check_field("slot_one", result.slot_one, want_report.slot_one);
                check_field("slot_two", result.slot_two, want_report.slot_two);
                check_field("slot_three", result.slot_three, want_report.slot_three);
                check_field("slot_four", result.slot_four, want_report.slot_four);
                check_field("slot_five", result.slot_five, want_report.slot_five);
                check_field("active_layer", result.active_layer, want_report.active_layer);
                check_field("led_level", result.led_level, want_report.led_level);
                check_field("boot_request", 8'(result.boot_request),
                            8'(want_report.boot_request));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int         counted;
        int         sel;
        logic [2:0] cls;
        logic [7:0] code;
        logic       down;

        clear_report_state();
        cur_layer = 8'h00;
        led_value = 8'h00;

        queue_event(CLS_KEY, 8'hFF, 1'b1);
        queue_event(CLS_KEY, 8'h00, 1'b1);
        queue_event(CLS_KEY, 8'h00, 1'b0);
        for (int k = 4; k <= 8; k++)
            queue_event(CLS_KEY, k[7:0], 1'b1);
        queue_event(CLS_KEY, 8'h09, 1'b1);
        queue_event(CLS_KEY, 8'h33, 1'b0);
        queue_event(CLS_KEY, 8'hFF, 1'b0);
        queue_event(CLS_MOD, 8'hFF, 1'b1);
        queue_event(CLS_MOD, 8'h80, 1'b0);
        queue_event(CLS_MOMENTARY, 8'hFF, 1'b1);
        queue_event(CLS_MOMENTARY, 8'h5A, 1'b0);
        queue_event(CLS_TOGGLE, 8'h05, 1'b1);
        queue_event(CLS_TOGGLE, 8'h05, 1'b1);
        queue_event(CLS_TOGGLE, 8'h07, 1'b0);
        queue_event(CLS_MISC, MISC_BOOT, 1'b1);
        queue_event(CLS_MISC, MISC_BOOT, 1'b0);
        queue_event(CLS_MISC, MISC_BRIGHTER, 1'b1);
        queue_event(CLS_MISC, MISC_DIMMER, 1'b1);
        queue_event(CLS_MISC, MISC_DIMMER, 1'b1);
        queue_event(CLS_MISC, 8'hFF, 1'b1);
        queue_event(CLS_MEDIA, 8'hA5, 1'b1);
        queue_event(CLS_MOUSE, 8'h5A, 1'b0);
        queue_event(CLS_UNKNOWN, 8'hFF, 1'b1);

        // keys mostly from a small pool so releases match and the slots fill up
        counted = 0;
        while (counted < 900)
        begin
            sel  = $urandom_range(0, 99);
            down = 1'($urandom_range(0, 1));
            sel  = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7)
                code = 8'($urandom_range(1, 10));
            else if ($urandom_range(0, 3) == 0)
                code = 8'h00;
            else
                code = 8'($urandom_range(0, 255));
            if (sel < 40)
            begin
                cls  = CLS_KEY;
                down = 1'b1;
            end
            else if (sel < 68)
            begin
                cls  = CLS_KEY;
                down = 1'b0;
            end
            else if (sel < 76)
            begin
                cls  = CLS_MOD;
                code = 8'($urandom_range(0, 255));
            end
            else if (sel < 81)
                cls = CLS_MOMENTARY;
            else if (sel < 86)
            begin
                cls  = CLS_TOGGLE;
                code = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 3));
            end
            else if (sel < 95)
            begin
                cls  = CLS_MISC;
                down = ($urandom_range(0, 4) != 0);
                case ($urandom_range(0, 6))
                    0:       code = MISC_BOOT;
                    1, 2, 3: code = MISC_BRIGHTER;
                    4, 5:    code = MISC_DIMMER;
                    default: code = 8'($urandom_range(0, 255));
                endcase
            end
            else
                cls = ($urandom_range(0, 2) == 0) ? CLS_MEDIA :
                      ($urandom_range(0, 1) == 0) ? CLS_MOUSE : CLS_UNKNOWN;
            queue_event(cls, code, down);
            counted++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (key_events.size() != 0 || start)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SLOT_COUNT + 6) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: hid_key_report_builder.f
rtl/core/hkrb_pkg.sv
rtl/core/hkrb_ctrl.sv
rtl/core/hkrb_dp.sv
rtl/core/hid_key_report_builder.sv
tb/tb.sv
